// File: rtl/tilt_to_led_dot_display_core_defines.svh
// Assertion macros for the tilt dot display core and its checker.
// Depends on nothing; included by the checker file.
`ifndef TILT_TO_LED_DOT_DISPLAY_CORE_DEFINES_SVH
`define TILT_TO_LED_DOT_DISPLAY_CORE_DEFINES_SVH

// Overlapping implication, sampled at the rising clock edge, off during reset.
`define TDD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication checked in the cycle after the antecedent holds.
`define TDD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/tdd_pkg.sv
// Shared types, codes and constant helpers for the tilt dot display core.
// Depends on nothing; used by every module of the block.
package tdd_pkg;

   localparam logic REQ_RENDER = 1'b0;
   localparam logic REQ_BUTTON = 1'b1;

   localparam logic MAP_LINEAR = 1'b0;
   localparam logic MAP_TANH   = 1'b1;

   // Positions are carried at the width of the largest supported matrix.
   localparam int POS_MAX_W = 4;
   // Width of a clamped acceleration and of a mapping threshold.
   localparam int THR_W = 17;

   typedef struct packed {
      logic               req_type;
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
   } req_beat_type;

   typedef struct packed {
      logic [2:0] column;
      logic [7:0] column_bits;
      logic       last;
      logic       compare_flag;
   } rsp_beat_type;

   typedef struct packed {
      logic [POS_MAX_W-1:0] bub_row;
      logic [POS_MAX_W-1:0] bub_col;
      logic [POS_MAX_W-1:0] sav_row;
      logic [POS_MAX_W-1:0] sav_col;
      logic                 cmp;
   } job_type;

   // Natural logarithm of 1..15 in units of 1e-12, used for the tanh thresholds.
   function automatic longint ln_e12(input int idx);
      longint res;
      case (idx)
         2:       res = 64'sd693147180560;
         3:       res = 64'sd1098612288668;
         4:       res = 64'sd1386294361120;
         5:       res = 64'sd1609437912434;
         6:       res = 64'sd1791759469228;
         7:       res = 64'sd1945910149055;
         8:       res = 64'sd2079441541680;
         9:       res = 64'sd2197224577336;
         10:      res = 64'sd2302585092994;
         11:      res = 64'sd2397895272798;
         12:      res = 64'sd2484906649788;
         13:      res = 64'sd2564949357462;
         14:      res = 64'sd2639057329615;
         15:      res = 64'sd2708050201102;
         default: res = 64'sd0;
      endcase
      return res;
   endfunction

endpackage

// File: rtl/tilt_to_led_dot_display_core.sv
// Top level of the tilt dot display core.
// Depends on tdd_pkg, tdd_map, tdd_track and tdd_scan.
//
// The req channel takes one beat per item: a render sample with X and Y
// acceleration, or a button press that toggles compare mode and saves or
// drops the stored dot. A render sample yields MATRIX_SIZE beats on the rsp
// channel, one per LED column, with last set on the final column. A button
// press yields no beat. The csr port writes the mapping mode (reset: tanh).
// A render sample passes the input register, the frame holder and the scanner
// before the output register. The scanner emits one beat per cycle while rsp
// is not stalled; button beats pass at one per cycle. One frame waits in a
// holding register while the scanner drains the previous one. A stall on rsp
// holds the output register and scanner; req_stall rises when the input
// register holds a render sample and the frame holder is full and not taken.
// Reset is synchronous and empties all stages, clears compare mode, places
// the live dot at row 0, column 0 and sets the tanh mapping.
module tilt_to_led_dot_display_core #(
   parameter int MATRIX_SIZE = 8,
   parameter int ONE_G       = 16384
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tdd_pkg::req_beat_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output tdd_pkg::rsp_beat_type rsp_data,
   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data
);

   logic             job_vld;
   logic             job_take;
   tdd_pkg::job_type job;

   tdd_track #(.MATRIX_SIZE(MATRIX_SIZE), .ONE_G(ONE_G)) u_track (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .job_vld     (job_vld),
      .job         (job),
      .job_take    (job_take)
   );

   tdd_scan #(.MATRIX_SIZE(MATRIX_SIZE)) u_scan (
      .clock     (clock),
      .reset     (reset),
      .job_vld   (job_vld),
      .job       (job),
      .job_take  (job_take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/tdd_map.sv
// Maps one acceleration to a dot position by counting thresholds at or below it.
// Depends on tdd_pkg; instantiated once per axis by tdd_track.
module tdd_map #(
   parameter int MATRIX_SIZE = 8,
   parameter int ONE_G       = 16384
) (
   input  logic                           map_mode,
   input  logic signed [15:0]             accel,
   output logic [$clog2(MATRIX_SIZE)-1:0] pos
);

   localparam int POS_W = $clog2(MATRIX_SIZE);
   localparam int NTHR  = MATRIX_SIZE - 1;
   localparam logic signed [tdd_pkg::THR_W-1:0] G_POS = tdd_pkg::THR_W'(ONE_G);
   localparam logic signed [tdd_pkg::THR_W-1:0] G_NEG = tdd_pkg::THR_W'(-ONE_G);

   logic signed [tdd_pkg::THR_W-1:0] v_ext;
   logic signed [tdd_pkg::THR_W-1:0] v_clamp;
   logic [NTHR-1:0]                  hit;

   assign v_ext = {accel[15], accel};

   always_comb begin
      if (v_ext > G_POS) begin
         v_clamp = G_POS;
      end else if (v_ext < G_NEG) begin
         v_clamp = G_NEG;
      end else begin
         v_clamp = v_ext;
      end
   end

   for (genvar k = 1; k < MATRIX_SIZE; k++) begin : g_thr
      localparam longint LIN_T =
         (longint'(2) * ONE_G * k + MATRIX_SIZE - 2) / (MATRIX_SIZE - 1) - ONE_G;
      localparam longint LN_D   = tdd_pkg::ln_e12(k) - tdd_pkg::ln_e12(MATRIX_SIZE - k);
      localparam longint LN_MAG = (LN_D < 0) ? -LN_D : LN_D;
      localparam longint TANH_M =
         (LN_MAG * ONE_G + 64'sd2000000000000) / 64'sd4000000000000;
      localparam longint TANH_T = (LN_D < 0) ? -TANH_M : TANH_M;
      localparam logic signed [tdd_pkg::THR_W-1:0] LIN_V  = tdd_pkg::THR_W'(LIN_T);
      localparam logic signed [tdd_pkg::THR_W-1:0] TANH_V = tdd_pkg::THR_W'(TANH_T);

      assign hit[k-1] = (map_mode == tdd_pkg::MAP_TANH) ? (v_clamp >= TANH_V)
                                                         : (v_clamp >= LIN_V);
   end

   always_comb begin
      pos = '0;
      for (int i = 0; i < NTHR; i++) begin
         pos = pos + POS_W'(hit[i]);
      end
   end

endmodule

// File: rtl/tdd_track.sv
// Input register, mode register and dot state; hands finished frames to the scanner.
// Depends on tdd_pkg and tdd_map.
module tdd_track #(
   parameter int MATRIX_SIZE = 8,
   parameter int ONE_G       = 16384
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tdd_pkg::req_beat_type req_data,
   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data,
   output logic                  job_vld,
   output tdd_pkg::job_type      job,
   input  logic                  job_take
);

   localparam int POS_W = $clog2(MATRIX_SIZE);

   logic                  in_vld_ff, in_vld_in;
   tdd_pkg::req_beat_type in_data_ff;
   logic                  map_mode_ff, map_mode_in;
   logic [POS_W-1:0]      bub_row_ff, bub_row_in;
   logic [POS_W-1:0]      bub_col_ff, bub_col_in;
   logic [POS_W-1:0]      sav_row_ff, sav_row_in;
   logic [POS_W-1:0]      sav_col_ff, sav_col_in;
   logic                  cmp_ff, cmp_in;
   logic                  job_vld_ff, job_vld_in;
   tdd_pkg::job_type      job_ff, job_in;
   logic [POS_W-1:0]      row_map;
   logic [POS_W-1:0]      col_map;
   logic                  is_button;
   logic                  a_go;
   logic                  req_accept;

   tdd_map #(.MATRIX_SIZE(MATRIX_SIZE), .ONE_G(ONE_G)) u_map_row (
      .map_mode (map_mode_ff),
      .accel    (in_data_ff.accel_x),
      .pos      (row_map)
   );

   tdd_map #(.MATRIX_SIZE(MATRIX_SIZE), .ONE_G(ONE_G)) u_map_col (
      .map_mode (map_mode_ff),
      .accel    (in_data_ff.accel_y),
      .pos      (col_map)
   );

   always_comb begin
      is_button  = in_data_ff.req_type == tdd_pkg::REQ_BUTTON;
      a_go       = in_vld_ff && (is_button || !job_vld_ff || job_take);
      req_stall  = in_vld_ff && !a_go;
      req_accept = req_valid && !req_stall;
      in_vld_in  = req_accept || (in_vld_ff && !a_go);

      map_mode_in = csr_wr_en ? csr_wr_data : map_mode_ff;

      bub_row_in = bub_row_ff;
      bub_col_in = bub_col_ff;
      sav_row_in = sav_row_ff;
      sav_col_in = sav_col_ff;
      cmp_in     = cmp_ff;
      job_in     = job_ff;
      job_vld_in = job_vld_ff && !job_take;

      if (a_go && is_button) begin
         if (cmp_ff) begin
            cmp_in = 1'b0;
         end else begin
            cmp_in     = 1'b1;
            sav_row_in = bub_row_ff;
            sav_col_in = bub_col_ff;
         end
      end else if (a_go) begin
         bub_row_in     = row_map;
         bub_col_in     = col_map;
         job_vld_in     = 1'b1;
         job_in.bub_row = tdd_pkg::POS_MAX_W'(row_map);
         job_in.bub_col = tdd_pkg::POS_MAX_W'(col_map);
         job_in.sav_row = tdd_pkg::POS_MAX_W'(sav_row_ff);
         job_in.sav_col = tdd_pkg::POS_MAX_W'(sav_col_ff);
         job_in.cmp     = cmp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         map_mode_ff <= tdd_pkg::MAP_TANH;
         bub_row_ff  <= '0;
         bub_col_ff  <= '0;
         cmp_ff      <= 1'b0;
         job_vld_ff  <= 1'b0;
      end else begin
         in_vld_ff   <= in_vld_in;
         map_mode_ff <= map_mode_in;
         bub_row_ff  <= bub_row_in;
         bub_col_ff  <= bub_col_in;
         cmp_ff      <= cmp_in;
         job_vld_ff  <= job_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
      sav_row_ff <= sav_row_in;
      sav_col_ff <= sav_col_in;
      job_ff     <= job_in;
   end

   assign job_vld = job_vld_ff;
   assign job     = job_ff;

endmodule

// File: rtl/tdd_scan.sv
// Column scanner: turns one frame into a run of column beats behind an output register.
// Depends on tdd_pkg.
module tdd_scan #(
   parameter int MATRIX_SIZE = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_vld,
   input  tdd_pkg::job_type      job,
   output logic                  job_take,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output tdd_pkg::rsp_beat_type rsp_data
);

   localparam int POS_W = $clog2(MATRIX_SIZE);
   localparam logic [POS_W-1:0] LAST_COL = POS_W'(MATRIX_SIZE - 1);

   logic                  busy_ff, busy_in;
   logic [POS_W-1:0]      col_ff, col_in;
   tdd_pkg::job_type      cur_ff, cur_in;
   logic                  rsp_vld_ff, rsp_vld_in;
   tdd_pkg::rsp_beat_type rsp_data_ff, rsp_data_in;
   logic                  out_free;
   logic                  at_end;
   logic                  emit;
   logic                  bub_hit;
   logic                  sav_hit;
   logic [7:0]            lit;

   always_comb begin
      out_free = !rsp_vld_ff || !rsp_stall;
      at_end   = col_ff == LAST_COL;
      emit     = busy_ff && out_free;
      job_take = job_vld && (!busy_ff || (out_free && at_end));

      bub_hit = tdd_pkg::POS_MAX_W'(col_ff) == cur_ff.bub_col;
      sav_hit = cur_ff.cmp && (tdd_pkg::POS_MAX_W'(col_ff) == cur_ff.sav_col);
      for (int r = 0; r < 8; r++) begin
         lit[r] = (bub_hit && (32'(cur_ff.bub_row) == r))
               || (sav_hit && (32'(cur_ff.sav_row) == r));
      end

      busy_in = busy_ff;
      col_in  = col_ff;
      cur_in  = cur_ff;
      if (job_take) begin
         busy_in = 1'b1;
         col_in  = '0;
         cur_in  = job;
      end else if (emit) begin
         busy_in = !at_end;
         col_in  = col_ff + POS_W'(1);
      end

      rsp_vld_in  = emit ? 1'b1 : (out_free ? 1'b0 : rsp_vld_ff);
      rsp_data_in = rsp_data_ff;
      if (emit) begin
         rsp_data_in.column       = 3'(col_ff);
         rsp_data_in.column_bits  = lit;
         rsp_data_in.last         = at_end;
         rsp_data_in.compare_flag = cur_ff.cmp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         col_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         busy_ff    <= busy_in;
         col_ff     <= col_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/tdd_checker.sv
// Port-level checks for the tilt dot display core, bound to its top level.
// Depends on tdd_pkg and tilt_to_led_dot_display_core_defines.svh.
`include "tilt_to_led_dot_display_core_defines.svh"

module tdd_checker #(
   parameter int MATRIX_SIZE = 8
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input tdd_pkg::rsp_beat_type rsp_data
);

   localparam logic [2:0] LAST_COL = 3'(MATRIX_SIZE - 1);

   logic rsp_accept;

   assign rsp_accept = rsp_valid && !rsp_stall;

   `TDD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "rsp beat changed while stalled")
   `TDD_ASSERT_NOW(a_last_col, clock, reset, rsp_valid && rsp_data.last, rsp_data.column == LAST_COL, "last beat is not on the final column")
   `TDD_ASSERT_NEXT(a_col_step, clock, reset, rsp_accept && !rsp_data.last, !rsp_valid || ((rsp_data.column == 3'($past(rsp_data.column) + 3'd1)) && (rsp_data.compare_flag == $past(rsp_data.compare_flag))), "column beats of one frame are out of step")
   `TDD_ASSERT_NEXT(a_frame_start, clock, reset, rsp_accept && rsp_data.last, !rsp_valid || (rsp_data.column == 3'd0), "frame does not start at column zero")
   `TDD_ASSERT_NOW(a_two_dots, clock, reset, rsp_valid, $countones(rsp_data.column_bits) <= 2, "more than two dots lit in one column")

endmodule

bind tilt_to_led_dot_display_core tdd_checker #(.MATRIX_SIZE(MATRIX_SIZE)) u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
